[rtl/btp_pkg.sv]
// Package for the barometer compensation block: types, codes and helpers.
`timescale 1ns / 1ps
package btp_pkg;

  localparam logic [19:0] SkipMark = 20'h80000;
  localparam logic [7:0]  RegTrimT  = 8'd0;
  localparam logic [7:0]  RegTrimP1 = 8'd1;
  localparam logic [7:0]  RegTrimP2 = 8'd2;
  localparam logic [7:0]  RegTrimP3 = 8'd3;
  localparam logic signed [63:0] TempMin = -64'sd4000;
  localparam logic signed [63:0] TempMax = 64'sd8500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_T_A,
    OP_T_BB,
    OP_T_V2,
    OP_T_5,
    OP_P_SQ,
    OP_P_6,
    OP_P_5,
    OP_P_3,
    OP_P_2,
    OP_P_1,
    OP_P_K,
    OP_P_DIV,
    OP_P_9,
    OP_P_Q,
    OP_P_8
  } op_e;

  // Sign-extend one 16-bit trim word
  function automatic logic [63:0] sext16(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  // Arithmetic shift right of a 64-bit two's complement word
  function automatic logic [63:0] asr64(logic [63:0] v, int unsigned n);
    return $signed(v) >>> n;
  endfunction

endpackage

[rtl/btp_if.sv]
// Request, result and trim-write channel interfaces.
`timescale 1ns / 1ps
interface btp_req_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btp_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] temperature_centi;
  logic        temperature_valid;
  logic [31:0] pressure_q24_8;
  logic        pressure_valid;
  modport source (output valid, temperature_centi, temperature_valid, pressure_q24_8,
                  pressure_valid, input ready);
  modport sink (input valid, temperature_centi, temperature_valid, pressure_q24_8,
                pressure_valid, output ready);
endinterface

interface btp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/baro_temp_pressure_compensation_top.sv]
// Top level: barometer temperature and pressure compensation sequencer.
`timescale 1ns / 1ps
// Usage:
//  - req_i carries one raw temperature / pressure pair; it is taken when
//    valid and ready are high at a clock edge. Ready is high only while the
//    sequencer is idle, so one request is worked on at a time.
//  - res_o returns one result per request from an output register, so the
//    next request may be taken while a result still waits.
//  - cfg_i writes the four trim registers (index 0..3, other indexes are
//    dropped); it is always ready and is to be used while the block idles.
//  - Work goes through a shift-add multiplier that takes one bit of its
//    narrow operand per cycle and a restoring divider that makes one
//    quotient bit per cycle.
//  - Work time is set by the serial multiplier and divider; a skipped
//    reading saves its share. A new request is taken only after the last
//    one has reached the output register.
//  - Reset clears trims, the fine temperature term and all control state.
//  - A stalled receiver holds the result; a finished request waits in its
//    last step until the output register frees.
module baro_temp_pressure_compensation_top (
  input  logic clk_i,
  input  logic rst_ni,
  btp_req_if.sink   req_i,
  btp_res_if.source res_o,
  btp_cfg_if.sink   cfg_i
);

  btp_pkg::state_e state_q, state_d;
  btp_pkg::op_e    op_q;

  logic [47:0] trim_t_q, trim_p1_q, trim_p2_q, trim_p3_q;
  logic [31:0] fine_q;
  logic [19:0] adc_t_q, adc_p_q;
  logic [63:0] r0_q, r1_q, r2_q, r3_q;

  // serial multiplier
  logic [63:0] acc_q, mul_a_q, mul_b_q;
  logic [5:0]  mul_cnt_q, mul_last_q;
  logic        mul_done;
  logic [63:0] acc_next;

  // serial divider
  logic [63:0] rem_q, quo_q, dvs_q;
  logic        neg_q;
  logic [5:0]  div_cnt_q;
  logic [63:0] rem_sh;
  logic        div_ge;

  logic [14:0] t_centi_q;
  logic        t_val_q;
  logic [31:0] p_out_q;
  logic        p_val_q;
  logic        out_valid_q;
  logic        out_free;

  logic        req_fire;
  logic [63:0] ld_a, ld_b;
  logic [5:0]  ld_last;
  logic [63:0] tv, pfin, q13, dv_n, dv_d;

  assign req_i.ready = (state_q == btp_pkg::ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || res_o.ready;

  assign mul_done = (mul_cnt_q == mul_last_q);
  assign acc_next = mul_b_q[0] ? (mul_done ? acc_q - mul_a_q : acc_q + mul_a_q) : acc_q;

  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign div_ge = (rem_sh >= dvs_q);

  assign q13  = btp_pkg::asr64(r0_q, 13);
  assign tv   = btp_pkg::asr64(acc_next + 64'd128, 8);
  assign pfin = btp_pkg::asr64(r0_q + r1_q + btp_pkg::asr64(acc_next, 19), 8)
              + (btp_pkg::sext16(trim_p3_q[15:0]) << 4);
  assign dv_n = r1_q;
  assign dv_d = r3_q;

  // Select multiplier operands for the current step
  always_comb begin
    ld_a    = '0;
    ld_b    = '0;
    ld_last = 6'd15;
    case (op_q)
      btp_pkg::OP_T_A: begin
        ld_a = {47'd0, adc_t_q[19:3]} - {47'd0, trim_t_q[15:0], 1'b0};
        ld_b = btp_pkg::sext16(trim_t_q[31:16]);
      end
      btp_pkg::OP_T_BB: begin
        ld_a    = {48'd0, adc_t_q[19:4]} - {48'd0, trim_t_q[15:0]};
        ld_b    = ld_a;
        ld_last = 6'd23;
      end
      btp_pkg::OP_T_V2: begin
        ld_a = r1_q;
        ld_b = btp_pkg::sext16(trim_t_q[47:32]);
      end
      btp_pkg::OP_T_5: begin
        ld_a    = r0_q;
        ld_b    = 64'd5;
        ld_last = 6'd3;
      end
      btp_pkg::OP_P_SQ: begin
        ld_a    = {{32{fine_q[31]}}, fine_q} - 64'd128000;
        ld_b    = ld_a;
        ld_last = 6'd39;
      end
      btp_pkg::OP_P_6: begin
        ld_a = r1_q;
        ld_b = btp_pkg::sext16(trim_p2_q[47:32]);
      end
      btp_pkg::OP_P_5: begin
        ld_a = r0_q;
        ld_b = btp_pkg::sext16(trim_p2_q[31:16]);
      end
      btp_pkg::OP_P_3: begin
        ld_a = r1_q;
        ld_b = btp_pkg::sext16(trim_p1_q[47:32]);
      end
      btp_pkg::OP_P_2: begin
        ld_a = r0_q;
        ld_b = btp_pkg::sext16(trim_p1_q[31:16]);
      end
      btp_pkg::OP_P_1: begin
        ld_a    = (64'd1 << 47) + r3_q;
        ld_b    = {48'd0, trim_p1_q[15:0]};
        ld_last = 6'd16;
      end
      btp_pkg::OP_P_K: begin
        ld_a    = ((64'd1048576 - {44'd0, adc_p_q}) << 31) - r2_q;
        ld_b    = 64'd3125;
        ld_last = 6'd12;
      end
      btp_pkg::OP_P_9: begin
        ld_a = q13;
        ld_b = btp_pkg::sext16(trim_p3_q[47:32]);
      end
      btp_pkg::OP_P_Q: begin
        ld_a    = r1_q;
        ld_b    = q13;
        ld_last = 6'd63;
      end
      btp_pkg::OP_P_8: begin
        ld_a = r0_q;
        ld_b = btp_pkg::sext16(trim_p3_q[31:16]);
      end
      default: begin
        ld_a = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      btp_pkg::ST_IDLE: if (req_fire) begin
        if (req_i.raw_temperature != btp_pkg::SkipMark ||
            req_i.raw_pressure != btp_pkg::SkipMark) state_d = btp_pkg::ST_LOAD;
        else state_d = btp_pkg::ST_OUT;
      end
      btp_pkg::ST_LOAD: begin
        state_d = (op_q == btp_pkg::OP_P_DIV) ? btp_pkg::ST_DIV : btp_pkg::ST_MUL;
      end
      btp_pkg::ST_MUL: if (mul_done) begin
        case (op_q)
          btp_pkg::OP_T_5:
            state_d = (adc_p_q != btp_pkg::SkipMark) ? btp_pkg::ST_LOAD : btp_pkg::ST_OUT;
          btp_pkg::OP_P_1:
            state_d = (btp_pkg::asr64(acc_next, 33) == '0) ? btp_pkg::ST_OUT
                                                            : btp_pkg::ST_LOAD;
          btp_pkg::OP_P_8: state_d = btp_pkg::ST_OUT;
          default:         state_d = btp_pkg::ST_LOAD;
        endcase
      end
      btp_pkg::ST_DIV: if (div_cnt_q == 6'd63) state_d = btp_pkg::ST_LOAD;
      btp_pkg::ST_OUT: if (out_free) state_d = btp_pkg::ST_IDLE;
      default: state_d = btp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Trim registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_t_q  <= '0;
      trim_p1_q <= '0;
      trim_p2_q <= '0;
      trim_p3_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        btp_pkg::RegTrimT:  trim_t_q  <= cfg_i.data;
        btp_pkg::RegTrimP1: trim_p1_q <= cfg_i.data;
        btp_pkg::RegTrimP2: trim_p2_q <= cfg_i.data;
        btp_pkg::RegTrimP3: trim_p3_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Sequencer control: step code, fine term, result flags, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= btp_pkg::OP_T_A;
      fine_q      <= '0;
      t_val_q     <= 1'b0;
      p_val_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just taken
      if (state_q == btp_pkg::ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (res_o.ready)                       out_valid_q <= 1'b0;
      case (state_q)
        btp_pkg::ST_IDLE: if (req_fire) begin
          t_val_q <= 1'b0;
          p_val_q <= 1'b0;
          op_q    <= (req_i.raw_temperature != btp_pkg::SkipMark) ? btp_pkg::OP_T_A
                                                                  : btp_pkg::OP_P_SQ;
        end
        btp_pkg::ST_MUL: if (mul_done) begin
          case (op_q)
            btp_pkg::OP_T_V2: fine_q <= 32'(r0_q + btp_pkg::asr64(acc_next, 14));
            btp_pkg::OP_T_5:  t_val_q <= 1'b1;
            btp_pkg::OP_P_8:  p_val_q <= 1'b1;
            default: ;
          endcase
          op_q <= (op_q == btp_pkg::OP_T_5) ? btp_pkg::OP_P_SQ : btp_pkg::op_e'(op_q + 4'd1);
        end
        btp_pkg::ST_DIV: if (div_cnt_q == 6'd63) op_q <= btp_pkg::OP_P_9;
        default: ;
      endcase
    end
  end

  // Datapath: serial multiplier, serial divider, work registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      btp_pkg::ST_IDLE: if (req_fire) begin
        adc_t_q   <= req_i.raw_temperature;
        adc_p_q   <= req_i.raw_pressure;
        t_centi_q <= '0;
        p_out_q   <= '0;
      end
      btp_pkg::ST_LOAD: begin
        if (op_q == btp_pkg::OP_P_DIV) begin
          rem_q     <= '0;
          quo_q     <= dv_n[63] ? 64'd0 - dv_n : dv_n;
          dvs_q     <= dv_d[63] ? 64'd0 - dv_d : dv_d;
          neg_q     <= dv_n[63] ^ dv_d[63];
          div_cnt_q <= '0;
        end else begin
          acc_q      <= '0;
          mul_a_q    <= ld_a;
          mul_b_q    <= ld_b;
          mul_last_q <= ld_last;
          mul_cnt_q  <= '0;
        end
        if (op_q == btp_pkg::OP_P_SQ) r0_q <= ld_a;
      end
      btp_pkg::ST_MUL: begin
        acc_q     <= acc_next;
        mul_a_q   <= mul_a_q << 1;
        mul_b_q   <= mul_b_q >> 1;
        mul_cnt_q <= mul_cnt_q + 6'd1;
        if (mul_done) begin
          case (op_q)
            btp_pkg::OP_T_A:  r0_q <= btp_pkg::asr64(acc_next, 11);
            btp_pkg::OP_T_BB: r1_q <= btp_pkg::asr64(acc_next, 12);
            btp_pkg::OP_T_V2: r0_q <= r0_q + btp_pkg::asr64(acc_next, 14);
            btp_pkg::OP_T_5: begin
              if ($signed(tv) < btp_pkg::TempMin)      t_centi_q <= 15'(btp_pkg::TempMin);
              else if ($signed(tv) > btp_pkg::TempMax) t_centi_q <= 15'(btp_pkg::TempMax);
              else                                     t_centi_q <= tv[14:0];
            end
            btp_pkg::OP_P_SQ: r1_q <= acc_next;
            btp_pkg::OP_P_6:  r2_q <= acc_next;
            btp_pkg::OP_P_5:
              r2_q <= r2_q + (acc_next << 17) + (btp_pkg::sext16(trim_p2_q[15:0]) << 35);
            btp_pkg::OP_P_3:  r3_q <= btp_pkg::asr64(acc_next, 8);
            btp_pkg::OP_P_2:  r3_q <= r3_q + (acc_next << 12);
            btp_pkg::OP_P_1:  r3_q <= btp_pkg::asr64(acc_next, 33);
            btp_pkg::OP_P_K:  r1_q <= acc_next;
            btp_pkg::OP_P_9:  r1_q <= acc_next;
            btp_pkg::OP_P_Q:  r1_q <= btp_pkg::asr64(acc_next, 25);
            btp_pkg::OP_P_8:  p_out_q <= pfin[31:0];
            default: ;
          endcase
        end
      end
      btp_pkg::ST_DIV: begin
        rem_q     <= div_ge ? rem_sh - dvs_q : rem_sh;
        quo_q     <= {quo_q[62:0], div_ge};
        div_cnt_q <= div_cnt_q + 6'd1;
        if (div_cnt_q == 6'd63) begin
          r0_q <= neg_q ? 64'd0 - {quo_q[62:0], div_ge} : {quo_q[62:0], div_ge};
        end
      end
      btp_pkg::ST_OUT: if (out_free) begin
        res_o.temperature_centi <= t_centi_q;
        res_o.temperature_valid <= t_val_q;
        res_o.pressure_q24_8    <= p_out_q;
        res_o.pressure_valid    <= p_val_q;
      end
      default: ;
    endcase
  end

  assign res_o.valid = out_valid_q;

endmodule

[bench/btp_scoreboard.sv]
// Watches the request, result and trim channels, predicts each result and compares.
`timescale 1ns / 1ps
module btp_scoreboard
  import btp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  btp_req_if   req_i,
  btp_res_if   res_i,
  btp_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [14:0] temperature_centi;
    logic        temperature_valid;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;
  } comp_result_t;

  logic [47:0] trim_t, trim_p_lo, trim_p_mid, trim_p_hi;
  logic [31:0] t_fine;
  comp_result_t awaited_q[$];
  int fails;

  // 16-bit trim word k, sign- or zero-extended
  function automatic logic [63:0] tword(logic [47:0] r, int k, bit sgn);
    logic [15:0] w;
    w = r[16*k +: 16];
    return sgn ? {{48{w[15]}}, w} : {48'd0, w};
  endfunction

  function automatic logic [63:0] shr_a(logic [63:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  // Signed divide truncating toward zero, wrapping like the hardware
  function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // Compensate one raw pair; updates the fine temperature term
  function automatic comp_result_t compensate(logic [19:0] adc_t_raw, logic [19:0] adc_p_raw);
    comp_result_t r;
    logic [63:0] adc_t, adc_p, a, b, v1, v2, tf, tv, p, q13;
    adc_t = {44'd0, adc_t_raw};
    adc_p = {44'd0, adc_p_raw};
    r = '0;
    if (adc_t_raw != SkipMark) begin
      a  = (adc_t >> 3) - tword(trim_t, 0, 0) * 2;
      v1 = shr_a(a * tword(trim_t, 1, 1), 11);
      b  = (adc_t >> 4) - tword(trim_t, 0, 0);
      v2 = shr_a(shr_a(b * b, 12) * tword(trim_t, 2, 1), 14);
      tf = v1 + v2;
      t_fine = tf[31:0];
      tv = shr_a(tf * 5 + 128, 8);
      if ($signed(tv) < TempMin) tv = TempMin;
      else if ($signed(tv) > TempMax) tv = TempMax;
      r.temperature_centi = tv[14:0];
      r.temperature_valid = 1'b1;
    end
    if (adc_p_raw != SkipMark) begin
      tf = {{32{t_fine[31]}}, t_fine};
      v1 = tf - 64'd128000;
      v2 = v1 * v1 * tword(trim_p_mid, 2, 1);
      v2 = v2 + ((v1 * tword(trim_p_mid, 1, 1)) << 17);
      v2 = v2 + (tword(trim_p_mid, 0, 1) << 35);
      v1 = shr_a(v1 * v1 * tword(trim_p_lo, 2, 1), 8) + ((v1 * tword(trim_p_lo, 1, 1)) << 12);
      v1 = shr_a(((64'd1 << 47) + v1) * tword(trim_p_lo, 0, 0), 33);
      if (v1 != 0) begin
        p   = 64'd1048576 - adc_p;
        p   = div_trunc(((p << 31) - v2) * 3125, v1);
        q13 = shr_a(p, 13);
        v1  = shr_a(tword(trim_p_hi, 2, 1) * q13 * q13, 25);
        v2  = shr_a(tword(trim_p_hi, 1, 1) * p, 19);
        p   = shr_a(p + v1 + v2, 8) + (tword(trim_p_hi, 0, 1) << 4);
        r.pressure_q24_8 = p[31:0];
        r.pressure_valid = 1'b1;
      end
    end
    return r;
  endfunction

  assign fail_count_o = fails;
  assign pending_o    = awaited_q.size();

  // Track trims, predict on each request and compare each result
  always @(posedge clk_i or negedge rst_ni) begin
    comp_result_t got, want;
    if (!rst_ni) begin
      trim_t <= '0; trim_p_lo <= '0; trim_p_mid <= '0; trim_p_hi <= '0;
      t_fine = '0;
      fails  = 0;
      awaited_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegTrimT:  trim_t     <= cfg_i.data;
          RegTrimP1: trim_p_lo  <= cfg_i.data;
          RegTrimP2: trim_p_mid <= cfg_i.data;
          RegTrimP3: trim_p_hi  <= cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready)
        awaited_q.push_back(compensate(req_i.raw_temperature, req_i.raw_pressure));
      if (res_i.valid && res_i.ready) begin
        got = {res_i.temperature_centi, res_i.temperature_valid,
               res_i.pressure_q24_8, res_i.pressure_valid};
        if (awaited_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result with nothing expected: %h", got);
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: temp %0d/%b press %h/%b, expected temp %0d/%b press %h/%b",
                       $signed(got.temperature_centi), got.temperature_valid,
                       got.pressure_q24_8, got.pressure_valid,
                       $signed(want.temperature_centi), want.temperature_valid,
                       want.pressure_q24_8, want.pressure_valid);
          end
        end
      end
    end
  end

endmodule

[bench/baro_temp_pressure_compensation_top_tb.sv]
// Stimulus and verdict for the barometer compensation block.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_top_tb;
  import btp_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, cycles;
  bit   calm = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  btp_req_if req_ch();
  btp_res_if res_ch();
  btp_cfg_if cfg_ch();

  baro_temp_pressure_compensation_top DUT (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(req_ch), .res_o(res_ch), .cfg_i(cfg_ch)
  );

  btp_scoreboard u_scoreboard (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch), .res_i(res_ch), .cfg_i(cfg_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result receiver: random stall bursts, plus the long hold-off when asked
  initial res_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 4);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Offer one request, keeping valid high into the next one
  task automatic send_pair(input logic [19:0] t_raw, input logic [19:0] p_raw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.raw_temperature <= t_raw;
    req_ch.raw_pressure <= p_raw;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Drain, then write all four trim registers
  task automatic load_trims(input logic [47:0] t, input logic [47:0] p_lo,
                            input logic [47:0] p_mid, input logic [47:0] p_hi);
    logic [47:0] vals [4];
    logic [7:0]  idx [4];
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    vals = '{t, p_lo, p_mid, p_hi};
    idx  = '{RegTrimT, RegTrimP1, RegTrimP2, RegTrimP3};
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly full-range raw values, with skips and edge values mixed in
  function automatic logic [19:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return SkipMark;
      1: begin
        case ($urandom_range(0, 3))
          0: return 20'h00000;
          1: return 20'hFFFFF;
          2: return 20'h7FFFF;
          default: return 20'h80001;
        endcase
      end
      default: return 20'($urandom());
    endcase
  endfunction

  task automatic random_pairs(input int n);
    for (int i = 0; i < n; i++) send_pair(pick_raw(), pick_raw());
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  initial begin
    logic [19:0] edge_raw [6];
    req_ch.valid = 1'b0;
    req_ch.raw_temperature = '0;
    req_ch.raw_pressure = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Typical factory trims: directed corners first
    load_trims({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
    edge_raw = '{20'h00000, 20'hFFFFF, SkipMark, 20'h7FFFF, 20'd519888, 20'd415148};
    send_pair(SkipMark, 20'd415148);   // pressure before any temperature
    foreach (edge_raw[i])
      foreach (edge_raw[j])
        if ((i + j) % 2 == 0 || i == j) send_pair(edge_raw[i], edge_raw[j]);
    send_pair(20'd519888, SkipMark);
    send_pair(SkipMark, SkipMark);

    // Hold the receiver off long enough for the block to back up
    hold_left = 1500;
    random_pairs(120);

    // Zero trims: divisor is zero, pressure never valid
    load_trims('0, '0, '0, '0);
    random_pairs(60);

    // All ones: unsigned words at maximum, signed words at -1
    load_trims('1, '1, '1, '1);
    random_pairs(60);

    // Signed extremes and saturation
    load_trims({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
    random_pairs(60);

    // Random trims
    for (int k = 0; k < 3; k++) begin
      load_trims(rand48(), rand48(), rand48(), rand48());
      random_pairs(60);
    end

    // Back to typical trims, no idling on either side
    load_trims({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
    calm = 1'b1;
    random_pairs(120);
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
